// ===== rtl/trial_division_prime_test_assert.svh =====
// Assertion macros used by the RTL file trial_division_prime_test.sv.
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TDPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tdpt_pkg.sv =====
`timescale 1ns / 1ps

package tdpt_pkg;

    localparam int NUMBER_WIDTH = 32;
    // Trial divisors never exceed sqrt(2^(NUMBER_WIDTH-1)) + 1.
    localparam int DIV_WIDTH    = NUMBER_WIDTH / 2 + 1;
    localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } rem_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } rem_sts_t;

endpackage

// ===== rtl/tdpt_rem.sv =====
`timescale 1ns / 1ps

// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
module tdpt_rem
    import tdpt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rem_ctl_t                ctl,
    input  logic [NUMBER_WIDTH-1:0] dividend,
    input  logic [DIV_WIDTH-1:0]    divisor,
    output rem_sts_t                sts
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_WIDTH-1:0]    cnt_reg, cnt_next;
    logic [NUMBER_WIDTH-1:0] num_reg, num_next;
    logic [DIV_WIDTH-1:0]    rem_reg, rem_next;

    logic [DIV_WIDTH:0]      trial;
    logic [DIV_WIDTH:0]      diff;
    logic                    ge;

    assign trial = {rem_reg, num_reg[NUMBER_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(NUMBER_WIDTH);
            num_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below divisor, so DIV_WIDTH bits hold it
            rem_next = ge ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
            num_next = {num_reg[NUMBER_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.zero = (rem_reg == '0);

endmodule

// ===== rtl/trial_division_prime_test.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_stall    number   (32 b, signed)
// output    out_valid / out_stall  is_prime (1 b)
//
// Divisors d = 2, 3, ... are tried while d*d <= number; d*d is kept by adding 2d+1.
// For each divisor the block passes through the check state, the bit-serial remainder
// in tdpt_rem and its done strobe. Negatives, 0 and 1 skip the divisor loop and go
// straight to DONE.
// in_stall is high from acceptance until the result enters the output register; a
// result held under out_stall only delays the following result. rst_n clears control.
module trial_division_prime_test
    import tdpt_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [NUMBER_WIDTH-1:0] number,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           is_prime
);

`include "trial_division_prime_test_assert.svh"

    state_t                  state_reg, state_next;
    logic [NUMBER_WIDTH-1:0] val_reg, val_next;
    logic [DIV_WIDTH-1:0]    d_reg, d_next;
    logic [NUMBER_WIDTH-1:0] sq_reg, sq_next;
    logic                    res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_bit_reg, out_bit_next;

    rem_ctl_t                rem_ctl;
    rem_sts_t                rem_sts;

    // d*d for the next divisor: (d+1)^2 = d^2 + 2d + 1
    logic [NUMBER_WIDTH-1:0] sq_step;
    assign sq_step = NUMBER_WIDTH'({d_reg, 1'b1});

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_bit_next   = out_bit_reg;
        rem_ctl.start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    val_next = number;
                    d_next   = DIV_WIDTH'(2);
                    sq_next  = NUMBER_WIDTH'(4);
                    // negative, zero, one: not prime
                    if (number[NUMBER_WIDTH-1] || (number[NUMBER_WIDTH-1:1] == '0))
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > val_reg)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_ctl.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_sts.done)
                begin
                    if (rem_sts.zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        d_next     = d_reg + DIV_WIDTH'(1);
                        sq_next    = sq_reg + sq_step;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        res_reg     <= res_next;
        out_bit_reg <= out_bit_next;
    end

    tdpt_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rem_ctl),
        .dividend (val_reg),
        .divisor  (d_reg),
        .sts      (rem_sts)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = out_bit_reg;

    // remainder unit is working or just finished whenever we wait on it
    `TDPT_ASSERT_NOW(a_div_waits_unit, state_reg == ST_DIV,
        rem_sts.busy || rem_sts.done, "DIV state without active remainder unit")
    // only nonnegative values of two or more reach the divisor loop
    `TDPT_ASSERT_NOW(a_check_range, state_reg == ST_CHECK,
        !val_reg[NUMBER_WIDTH-1] && (d_reg >= DIV_WIDTH'(2)) && (sq_reg >= NUMBER_WIDTH'(4)),
        "divisor loop entered with bad operands")
    // a new result appears only when leaving DONE
    `TDPT_ASSERT_NOW(a_out_from_done, $rose(out_valid_reg),
        $past(state_reg == ST_DONE), "output raised outside DONE")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tdpt_pkg::*;

    localparam int NW               = NUMBER_WIDTH;
    localparam int CLK_PERIOD       = 4;
    // The receiver holds off this long in the pressure burst. A small request
    // tries at most 15 divisors, so at least two results come due, the output
    // register fills and in_stall has to rise.
    localparam int HOLD_OFF_CYCLES  = 2000;
    localparam int PRESSURE_COUNT   = 6;
    localparam int RANDOM_PER_PHASE = 18;
    // The slowest request sent is the prime just below 2^24, which tries about
    // 4096 divisors. The limit leaves ample room for it.
    localparam int WATCHDOG_LIMIT   = 600000;
    // Allow slack past the last result.
    localparam int DRAIN_CYCLES     = 50;
    localparam int MAX_REPORTS      = 10;

    // Holds the expected verdict of every request that has been accepted
    // and has no result yet, oldest first.
    class prime_scoreboard;
        bit                   verdict_q[$];
        logic signed [NW-1:0] number_q[$];
        int                   mismatches;

        // Smallest divisor d with d*d <= value and d <= cap. Returns 0 if
        // no such divisor exists.
        static function longint unsigned first_factor(longint unsigned value,
                                                      longint unsigned cap);
            longint unsigned d;
            for (d = 2; d * d <= value && d <= cap; d++)
                if (value % d == 0)
                    return d;
            return 0;
        endfunction

        function bit predict_prime(logic signed [NW-1:0] n);
            if (n[NW-1] || n < 2)
                return 1'b0;
            return first_factor(longint'(n), '1) == 0;
        endfunction

        function void note_request(logic signed [NW-1:0] n);
            number_q.push_back(n);
            verdict_q.push_back(predict_prime(n));
        endfunction

        function void check_verdict(logic got);
            logic signed [NW-1:0] n;
            bit                   want;
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: is_prime=%0b with no request pending", $time, got);
                return;
            end
            n    = number_q.pop_front();
            want = verdict_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: number %0d: is_prime expected %0b, actual %0b",
                             $time, n, want, got);
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [NW-1:0] number;
    logic                 out_valid;
    logic                 out_stall;
    logic                 is_prime;

    prime_scoreboard      sb;
    int unsigned          send_idle_pct;
    int unsigned          stall_pct;
    bit                   hold_off_req = 1'b0;
    bit                   hold_off_taken = 1'b0;
    int unsigned          quiet_cycles = 0;

    // Idle percentages per random phase: none, sender, receiver, both.
    int unsigned          send_idle_by_phase[4] = '{0, 85, 0, 29};
    int unsigned          stall_by_phase[4]     = '{0, 0, 85, 29};

    // Edges of the field, negatives, squares of primes (the divisor loop
    // must include d*d == n), the two primes where no divisor is tried,
    // and a few larger primes that run the divisor loop for longer.
    logic signed [NW-1:0] directed_numbers[$] = '{
        0, 1, 2, 3, 4, 5, 8, 9, 25, 49, 97, 121,
        -1, -2, 32'h8000_0000, 32'hAAAA_AAAA,
        32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h5555_5555,
        65521, 65536, 1048573, 16777213
    };

    trial_division_prime_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .number    (number),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit roll(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // Most requests are small, so each one costs few divisors. Large
    // positives are kept only when they have a small factor, because a
    // large prime would try up to about 46340 divisors.
    function automatic logic signed [NW-1:0] random_number();
        int unsigned   pick;
        logic [NW-1:0] v;
        pick = $urandom_range(99);
        v    = NW'({$urandom(), $urandom()});
        if (pick < 15)
            v[NW-1] = 1'b1;
        else if (pick < 55)
            v = $urandom_range(255);
        else if (pick < 80)
            v = $urandom_range(65535);
        else
        begin
            v[NW-1] = 1'b0;
            while (prime_scoreboard::first_factor(longint'(v), 64) == 0)
            begin
                v       = NW'({$urandom(), $urandom()});
                v[NW-1] = 1'b0;
            end
        end
        return v;
    endfunction

    // Offers one request, with random idle cycles ahead of it, and logs it
    // with the scoreboard at the edge where it is accepted. Valid stays high
    // into the next call when that call adds no idle cycle.
    task automatic send_request(input logic signed [NW-1:0] n);
        while (roll(send_idle_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= n;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(n);
    endtask

    // Receiver: random stall at each edge. When the main flow asks for it,
    // it holds off once for a long stretch.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_taken)
            begin
                hold_off_taken = 1'b1;
                out_stall     <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_stall <= roll(stall_pct);
        end
    end

    // Results are checked at the edge where they are accepted. The values
    // read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_verdict(is_prime);
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        number        = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        sb            = new();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests, back to back.
        foreach (directed_numbers[i])
            send_request(directed_numbers[i]);

        // Pressure burst: the receiver holds off while the sender keeps
        // offering small requests, so the block fills up and stalls.
        hold_off_req <= 1'b1;
        repeat (PRESSURE_COUNT) send_request($urandom_range(255));

        // Random requests under each idle pattern in turn.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_idle_by_phase[phase];
            stall_pct     = stall_by_phase[phase];
            repeat (RANDOM_PER_PHASE) send_request(random_number());
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
